FILE: rtl/rti_pkg.sv
// shared types and constants for the ray / triangle intersection block
// no dependencies
`default_nettype none

package rti_pkg;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 63;
  localparam int TOL_W     = 20;
  localparam logic [TOL_W-1:0] TOL_RESET = 20'd1;

  // ray parameter quotient: fixed by the 59-bit scaling of the plane distance
  localparam int TQ_W    = 62;
  localparam int TQ_LO_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VERTEX_A   = 3'd0,
    REG_VERTEX_B   = 3'd1,
    REG_VERTEX_C   = 3'd2,
    REG_NORMAL     = 3'd3,
    REG_TOLERANCE  = 3'd4
  } rti_reg_e;

  // per-stage control that travels with each word
  typedef struct packed {
    logic valid;
    logic miss;
  } rti_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/rti_div.sv
// pipelined restoring divider, one quotient bit per stage, with a tag carried alongside
// depends on rti_pkg
`default_nettype none

module rti_div
  import rti_pkg::*;
#(
  parameter int NUM_W = 62,
  parameter int DEN_W = 23,
  parameter int TAG_W = 126
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire rti_ctl_t         ctl_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [TAG_W-1:0] tag_i,
  output rti_ctl_t              ctl_o,
  output logic [NUM_W-1:0]      quo_o,
  output logic [TAG_W-1:0]      tag_o
);

  rti_ctl_t         ctl_q [NUM_W];
  logic [DEN_W-1:0] rem_q [NUM_W];
  logic [DEN_W-1:0] rem_d [NUM_W];
  logic [NUM_W-1:0] nq_q  [NUM_W];
  logic [NUM_W-1:0] nq_d  [NUM_W];
  logic [DEN_W-1:0] den_q [NUM_W];
  logic [TAG_W-1:0] tag_q [NUM_W];

  // one restoring step: shift in the next numerator bit, subtract if it fits
  function automatic logic [DEN_W+NUM_W-1:0] div_step(input logic [DEN_W-1:0] rem,
                                                       input logic [NUM_W-1:0] nq,
                                                       input logic [DEN_W-1:0] den);
    logic [DEN_W:0]   sh;
    logic [DEN_W+1:0] diff;
    sh   = {rem, nq[NUM_W-1]};
    diff = {1'b0, sh} - {2'b00, den};
    if (!diff[DEN_W+1]) begin
      return {diff[DEN_W-1:0], nq[NUM_W-2:0], 1'b1};
    end else begin
      return {sh[DEN_W-1:0], nq[NUM_W-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    {rem_d[0], nq_d[0]} = div_step('0, num_i, den_i);
    for (int k = 1; k < NUM_W; k++) begin
      {rem_d[k], nq_d[k]} = div_step(rem_q[k-1], nq_q[k-1], den_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_W; k++) ctl_q[k] <= '0;
    end else if (adv_i) begin
      ctl_q[0] <= ctl_i;
      for (int k = 1; k < NUM_W; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      den_q[0] <= den_i;
      tag_q[0] <= tag_i;
      for (int k = 1; k < NUM_W; k++) begin
        den_q[k] <= den_q[k-1];
        tag_q[k] <= tag_q[k-1];
      end
      for (int k = 0; k < NUM_W; k++) begin
        rem_q[k] <= rem_d[k];
        nq_q[k]  <= nq_d[k];
      end
    end
  end

  assign ctl_o = ctl_q[NUM_W-1];
  assign quo_o = nq_q[NUM_W-1];
  assign tag_o = tag_q[NUM_W-1];

endmodule

`default_nettype wire

FILE: rtl/ray_triangle_intersect.sv
// ray / triangle intersection, top level: configuration registers and the datapath pipeline
// depends on rti_pkg and rti_div
`default_nettype none

// One ray word enters per clock and one result word leaves per clock while the skid
// register is empty: four stages form the plane dot products and the reject tests, a
// 62-stage divider finds the ray parameter one quotient bit per stage, and seven stages
// form the hit point, the projected barycentric numerators and the edge test. The
// pipeline moves as one. When the sink stalls a finished word, that word drops into a
// one-word skid register and the pipeline moves once more; it holds only while the skid
// register is full, and then in_stall_o is high. in_stall_o is a register, so the sink's
// stall never reaches the input in the same cycle. The triangle, its normal and the
// zero tolerance sit in registers written through cfg_we_i, cfg_idx_i and cfg_wdata_i;
// write them only when no ray is in flight. A miss reports hit and on_edge low and a
// zero point.
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int COORD_BITS = 21,
  parameter int FRAC_BITS  = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [CFG_W-1:0]             cfg_wdata_i,
  // ray words
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] origin_x_i,
  input  wire logic signed [COORD_BITS-1:0] origin_y_i,
  input  wire logic signed [COORD_BITS-1:0] origin_z_i,
  input  wire logic signed [COORD_BITS-1:0] dir_x_i,
  input  wire logic signed [COORD_BITS-1:0] dir_y_i,
  input  wire logic signed [COORD_BITS-1:0] dir_z_i,
  // result words
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              hit_o,
  output logic                              on_edge_o,
  output logic signed [COORD_BITS-1:0]      point_x_o,
  output logic signed [COORD_BITS-1:0]      point_y_o,
  output logic signed [COORD_BITS-1:0]      point_z_o
);

  localparam int W      = COORD_BITS;
  localparam int NF     = W - 2;           // normal fraction bits
  localparam int SH     = 59 - W;          // ray parameter scaling
  localparam int TW     = W + 2;           // floored product term
  localparam int DNW    = W + 4;           // n.D
  localparam int TNW    = W + 5;           // n.A - n.O
  localparam int DEN_W  = W + 2;           // |n.D|
  localparam int MTN_W  = W + 3;           // |n.A - n.O|
  localparam int MW     = W + 4;           // step magnitude incl. saturated value
  localparam int PW     = W + 5;           // unsaturated hit point
  localparam int UW     = PW + 1;          // point minus vertex
  localparam int EW     = W + 1;           // edge vector component
  localparam int PRS    = 2 * EW;          // edge x edge product
  localparam int PRL    = UW + EW;         // point x edge product
  localparam int TWD    = PRS + 1;         // T
  localparam int XW     = PRL + 1;         // A', B'
  localparam int BW     = XW + 2;          // G and widened weights
  localparam int LW     = TWD + TOL_W;     // tol * |T|
  localparam int CW     = BW + FRAC_BITS + TOL_W;
  localparam int TAG_W  = 6 * W;
  localparam int FULL_W = TQ_W + W + 1;

  // ------------------------------------------------------------------
  // configuration registers
  // ------------------------------------------------------------------
  logic [CFG_W-1:0] va_q, vb_q, vc_q, nrm_q;
  logic [TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= '0;
      vb_q  <= '0;
      vc_q  <= '0;
      nrm_q <= '0;
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VERTEX_A:  va_q  <= cfg_wdata_i;
        REG_VERTEX_B:  vb_q  <= cfg_wdata_i;
        REG_VERTEX_C:  vc_q  <= cfg_wdata_i;
        REG_NORMAL:    nrm_q <= cfg_wdata_i;
        REG_TOLERANCE: tol_q <= cfg_wdata_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // a packed field reads zero bits past the top of the register
  function automatic logic [W-1:0] field(input logic [CFG_W-1:0] r, input int k);
    logic [3*W+CFG_W-1:0] ext;
    ext = {{(3*W){1'b0}}, r};
    return ext[k*W +: W];
  endfunction

  logic signed [W-1:0] n  [3];
  logic signed [W-1:0] va [3];
  logic signed [W-1:0] vb [3];
  logic signed [W-1:0] vc [3];
  logic [W-1:0]        nm [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i]  = $signed(field(nrm_q, i));
      va[i] = $signed(field(va_q, i));
      vb[i] = $signed(field(vb_q, i));
      vc[i] = $signed(field(vc_q, i));
      nm[i] = n[i][W-1] ? (~n[i] + 1'b1) : n[i];
    end
  end

  // projection axes: drop the normal's dominant axis, ties to the later branch
  logic [1:0] ax, bx;

  always_comb begin
    if (nm[0] > nm[1]) begin
      if (nm[0] > nm[2]) begin
        ax = 2'd1; bx = 2'd2;
      end else begin
        ax = 2'd0; bx = 2'd1;
      end
    end else if (nm[1] > nm[2]) begin
      ax = 2'd0; bx = 2'd2;
    end else begin
      ax = 2'd0; bx = 2'd1;
    end
  end

  // ------------------------------------------------------------------
  // pipeline control: everything moves unless the skid register is full
  // ------------------------------------------------------------------
  logic                skid_vld_q, skid_hit_q, skid_edge_q;
  logic signed [W-1:0] skid_pt_q [3];
  logic                adv;
  assign adv        = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // stage 0: input register
  rti_ctl_t            ctl0_q;
  logic signed [W-1:0] o0_q [3];
  logic signed [W-1:0] d0_q [3];

  // stage 1: floored product terms of the three dot products
  rti_ctl_t             ctl1_q;
  logic signed [TW-1:0] td_q [3];
  logic signed [TW-1:0] to_q [3];
  logic signed [TW-1:0] ta_q [3];
  logic signed [W-1:0]  o1_q [3];
  logic signed [W-1:0]  d1_q [3];
  logic signed [2*W-1:0] prd [3];
  logic signed [2*W-1:0] pro [3];
  logic signed [2*W-1:0] pra [3];

  // stage 2: dot product sums
  rti_ctl_t              ctl2_q;
  logic signed [DNW-1:0] dn_q;
  logic signed [TNW-1:0] tn_q;
  logic signed [W-1:0]   o2_q [3];
  logic signed [W-1:0]   d2_q [3];

  // stage 3: reject tests and divider operands
  rti_ctl_t            ctl3_q;
  logic [TQ_W-1:0]     num3_q;
  logic [DEN_W-1:0]    den3_q;
  logic signed [W-1:0] o3_q [3];
  logic signed [W-1:0] d3_q [3];
  logic [DNW-1:0]      adn;
  logic [TNW-1:0]      atn;
  logic                miss3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prd[i] = n[i] * d0_q[i];
      pro[i] = n[i] * o0_q[i];
      pra[i] = n[i] * va[i];
    end
    adn   = dn_q[DNW-1] ? DNW'(-dn_q) : DNW'(dn_q);
    atn   = tn_q[TNW-1] ? TNW'(-tn_q) : TNW'(tn_q);
    miss3 = ({{TOL_W{1'b0}}, adn} <= {{DNW{1'b0}}, tol_q})
         || (tn_q == '0) || (tn_q[TNW-1] != dn_q[DNW-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else if (adv) begin
      ctl0_q <= '{valid: in_valid_i, miss: 1'b0};
      ctl1_q <= ctl0_q;
      ctl2_q <= ctl1_q;
      ctl3_q <= '{valid: ctl2_q.valid, miss: miss3};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o0_q[0] <= origin_x_i;
      o0_q[1] <= origin_y_i;
      o0_q[2] <= origin_z_i;
      d0_q[0] <= dir_x_i;
      d0_q[1] <= dir_y_i;
      d0_q[2] <= dir_z_i;
      for (int i = 0; i < 3; i++) begin
        // taking the top bits is a floor shift
        td_q[i] <= prd[i][2*W-1:NF];
        to_q[i] <= pro[i][2*W-1:NF];
        ta_q[i] <= pra[i][2*W-1:NF];
        o1_q[i] <= o0_q[i];
        d1_q[i] <= d0_q[i];
        o2_q[i] <= o1_q[i];
        d2_q[i] <= d1_q[i];
        o3_q[i] <= o2_q[i];
        d3_q[i] <= d2_q[i];
      end
      dn_q   <= DNW'(td_q[0]) + DNW'(td_q[1]) + DNW'(td_q[2]);
      tn_q   <= (TNW'(ta_q[0]) + TNW'(ta_q[1]) + TNW'(ta_q[2]))
              - (TNW'(to_q[0]) + TNW'(to_q[1]) + TNW'(to_q[2]));
      num3_q <= {atn[MTN_W-1:0], {SH{1'b0}}};
      den3_q <= adn[DEN_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // ray parameter tq = (|tn| << SH) / |dn|
  // ------------------------------------------------------------------
  rti_ctl_t         ctl_dv;
  logic [TQ_W-1:0]  q_dv;
  logic [TAG_W-1:0] tag_dv;

  rti_div #(
    .NUM_W (TQ_W),
    .DEN_W (DEN_W),
    .TAG_W (TAG_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (ctl3_q),
    .num_i  (num3_q),
    .den_i  (den3_q),
    .tag_i  ({o3_q[2], o3_q[1], o3_q[0], d3_q[2], d3_q[1], d3_q[0]}),
    .ctl_o  (ctl_dv),
    .quo_o  (q_dv),
    .tag_o  (tag_dv)
  );

  logic signed [W-1:0] odv [3];
  logic signed [W-1:0] ddv [3];
  logic [W-1:0]        mdv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      odv[i] = $signed(tag_dv[(3+i)*W +: W]);
      ddv[i] = $signed(tag_dv[i*W +: W]);
      mdv[i] = ddv[i][W-1] ? (~ddv[i] + 1'b1) : ddv[i];
    end
  end

  // stage 4: tq * |D_i| as two partial products per axis
  rti_ctl_t                        ctl4_q;
  logic [TQ_W-TQ_LO_W+W-1:0]       pph_q [3];
  logic [TQ_LO_W+W-1:0]            ppl_q [3];
  logic [2:0]                      dneg4_q;
  logic signed [W-1:0]             o4_q [3];

  // stage 5: saturated step, unsaturated hit point
  rti_ctl_t             ctl5_q;
  logic signed [PW-1:0] p5_q [3];
  logic [FULL_W-1:0]    full [3];
  logic [MW-1:0]        stp  [3];
  logic signed [PW-1:0] sst  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full[i] = FULL_W'({pph_q[i], {TQ_LO_W{1'b0}}}) + FULL_W'(ppl_q[i]);
      // product at or above 2^62 clamps to 2^62
      if (full[i][FULL_W-1:TQ_W] != '0) begin
        stp[i] = MW'(1) << (MW - 1);
      end else begin
        stp[i] = MW'(full[i][TQ_W-1:SH]);
      end
      sst[i] = $signed(PW'(stp[i]));
    end
  end

  // stage 6: projected differences
  rti_ctl_t             ctl6_q;
  logic signed [UW-1:0] u0_q, v0_q;
  logic signed [EW-1:0] u1_q, u2_q, v1_q, v2_q;
  logic signed [PW-1:0] p6_q [3];

  // stage 7: cross products
  rti_ctl_t              ctl7_q;
  logic signed [PRS-1:0] ps1_q, ps2_q;
  logic signed [PRL-1:0] pl1_q, pl2_q, pl3_q, pl4_q;
  logic signed [PW-1:0]  p7_q [3];

  // stage 8: T, A', B'
  rti_ctl_t              ctl8_q;
  logic signed [TWD-1:0] t8_q;
  logic signed [XW-1:0]  a8_q, b8_q;
  logic signed [PW-1:0]  p8_q [3];

  // stage 9: sign tests, weight magnitudes and edge limit
  rti_ctl_t             ctl9_q;
  logic [LW-1:0]        lim9_q;
  logic [BW-1:0]        abs9_q [3];
  logic signed [PW-1:0] p9_q [3];
  logic signed [BW-1:0] wx [3];
  logic [BW-1:0]        wabs [3];
  logic [TWD-1:0]       at;
  logic                 miss9;

  always_comb begin
    wx[0] = BW'(a8_q);
    wx[1] = BW'(b8_q);
    wx[2] = BW'(t8_q) - BW'(a8_q) - BW'(b8_q);
    at    = t8_q[TWD-1] ? TWD'(-t8_q) : TWD'(t8_q);
    miss9 = ctl8_q.miss || ({{TOL_W{1'b0}}, at} <= {{TWD{1'b0}}, tol_q});
    for (int i = 0; i < 3; i++) begin
      wabs[i] = wx[i][BW-1] ? BW'(-wx[i]) : BW'(wx[i]);
      // a weight is negative when its numerator is nonzero and opposes T
      if ((wx[i] != '0) && (wx[i][BW-1] != t8_q[TWD-1])) miss9 = 1'b1;
    end
  end

  // stage 10: output register, backed by the skid register
  logic                ovld_q, hit_q, edge_q;
  logic signed [W-1:0] pt_q [3];
  logic                edge_hit;
  logic [CW-1:0]       lim_ext;

  always_comb begin
    lim_ext  = CW'(lim9_q);
    edge_hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (CW'({abs9_q[i], {FRAC_BITS{1'b0}}}) <= lim_ext) edge_hit = 1'b1;
    end
  end

  function automatic logic [W-1:0] sat_pt(input logic signed [PW-1:0] v);
    logic [PW-W:0] hi;
    hi = v[PW-1:W-1];
    if ((&hi) || !(|hi)) begin
      return v[W-1:0];
    end else if (v[PW-1]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
      ctl5_q <= '0;
      ctl6_q <= '0;
      ctl7_q <= '0;
      ctl8_q <= '0;
      ctl9_q <= '0;
      ovld_q <= 1'b0;
    end else if (adv) begin
      ctl4_q <= ctl_dv;
      ctl5_q <= ctl4_q;
      ctl6_q <= ctl5_q;
      ctl7_q <= ctl6_q;
      ctl8_q <= ctl7_q;
      ctl9_q <= '{valid: ctl8_q.valid, miss: miss9};
      ovld_q <= ctl9_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pph_q[i]   <= q_dv[TQ_W-1:TQ_LO_W] * mdv[i];
        ppl_q[i]   <= q_dv[TQ_LO_W-1:0] * mdv[i];
        dneg4_q[i] <= ddv[i][W-1];
        o4_q[i]    <= odv[i];
        p5_q[i]    <= PW'(o4_q[i]) + (dneg4_q[i] ? -sst[i] : sst[i]);
        p6_q[i]    <= p5_q[i];
        p7_q[i]    <= p6_q[i];
        p8_q[i]    <= p7_q[i];
        p9_q[i]    <= p8_q[i];
        abs9_q[i]  <= wabs[i];
        // a miss reports a zero point
        pt_q[i]    <= ctl9_q.miss ? '0 : $signed(sat_pt(p9_q[i]));
      end
      u0_q   <= UW'(p5_q[ax]) - UW'(va[ax]);
      v0_q   <= UW'(p5_q[bx]) - UW'(va[bx]);
      u1_q   <= EW'(vb[ax]) - EW'(va[ax]);
      u2_q   <= EW'(vc[ax]) - EW'(va[ax]);
      v1_q   <= EW'(vb[bx]) - EW'(va[bx]);
      v2_q   <= EW'(vc[bx]) - EW'(va[bx]);
      ps1_q  <= PRS'(u1_q) * PRS'(v2_q);
      ps2_q  <= PRS'(v1_q) * PRS'(u2_q);
      pl1_q  <= PRL'(u0_q) * PRL'(v2_q);
      pl2_q  <= PRL'(v0_q) * PRL'(u2_q);
      pl3_q  <= PRL'(u1_q) * PRL'(v0_q);
      pl4_q  <= PRL'(v1_q) * PRL'(u0_q);
      t8_q   <= TWD'(ps1_q) - TWD'(ps2_q);
      a8_q   <= XW'(pl1_q) - XW'(pl2_q);
      b8_q   <= XW'(pl3_q) - XW'(pl4_q);
      lim9_q <= LW'(at) * LW'(tol_q);
      hit_q  <= !ctl9_q.miss;
      edge_q <= !ctl9_q.miss && edge_hit;
    end
  end

  // skid register: takes the stage 10 word when the sink stalls it, empties on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (!out_stall_i) skid_vld_q <= 1'b0;
    end else if (ovld_q && out_stall_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q && ovld_q && out_stall_i) begin
      skid_hit_q  <= hit_q;
      skid_edge_q <= edge_q;
      for (int i = 0; i < 3; i++) skid_pt_q[i] <= pt_q[i];
    end
  end

  // the skid word is older than the stage 10 word
  assign out_valid_o = skid_vld_q || ovld_q;
  assign hit_o       = skid_vld_q ? skid_hit_q   : hit_q;
  assign on_edge_o   = skid_vld_q ? skid_edge_q  : edge_q;
  assign point_x_o   = skid_vld_q ? skid_pt_q[0] : pt_q[0];
  assign point_y_o   = skid_vld_q ? skid_pt_q[1] : pt_q[1];
  assign point_z_o   = skid_vld_q ? skid_pt_q[2] : pt_q[2];

`ifndef NO_ASSERTIONS
  a_miss_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> point_x_o == '0 && point_y_o == '0 && point_z_o == '0)
    else $error("missed ray carries a nonzero point");

  a_edge_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && on_edge_o |-> hit_o)
    else $error("edge flag without a hit");

  a_parallel_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl3_q.valid && den3_q == '0 |-> ctl3_q.miss)
    else $error("zero divisor not marked as a miss");
`endif

endmodule

`default_nettype wire
